FILE: rtl/core/mrx_pkg.sv
package mrx_pkg;

    typedef enum logic [5:0] {
        F_SLL = 6'd0, F_SRL = 6'd1, F_SRA = 6'd2, F_SLLV = 6'd3, F_SRLV = 6'd4,
        F_SRAV = 6'd5, F_DSLL = 6'd6, F_DSLL32 = 6'd7, F_DSRA32 = 6'd8,
        F_DSLLV = 6'd9, F_JR = 6'd10, F_JALR = 6'd11, F_SYNC = 6'd12,
        F_MFHI = 6'd13, F_MTHI = 6'd14, F_MFLO = 6'd15, F_MTLO = 6'd16,
        F_MULT = 6'd17, F_MULTU = 6'd18, F_DIV = 6'd19, F_DIVU = 6'd20,
        F_ADD = 6'd21, F_ADDU = 6'd22, F_SUB = 6'd23, F_SUBU = 6'd24,
        F_AND = 6'd25, F_OR = 6'd26, F_XOR = 6'd27, F_NOR = 6'd28,
        F_SLT = 6'd29, F_SLTU = 6'd30, F_DADD = 6'd31, F_DADDU = 6'd32,
        F_DSUB = 6'd33
    } t_func;

    typedef enum logic [1:0] {
        K_ALU = 2'd0, K_MUL = 2'd1, K_DIV = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0, S_MUL = 3'd1, S_DIV = 3'd2, S_DONE = 3'd3, S_OUT = 3'd4
    } t_state;

    localparam int QDEPTH = 2;
    localparam int DIV_STEPS = 32;

    typedef struct packed {
        logic [5:0]  func;
        t_kind       kind;
        logic [63:0] rs;
        logic [63:0] rt;
        logic [4:0]  sa;
        logic [4:0]  rd;
        logic [63:0] ra;
    } t_op;

    typedef struct packed {
        logic        write_enable;
        logic [4:0]  write_index;
        logic [63:0] write_value;
        logic        jump_taken;
        logic [63:0] jump_address;
        logic        overflow_trap;
    } t_res;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

FILE: rtl/core/mrx_if.sv
interface mrx_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  func;
    logic [63:0] source_value;
    logic [63:0] target_value;
    logic [4:0]  shift_amount;
    logic [4:0]  dest_index;
    logic [63:0] return_address;
    modport source(output valid, func, source_value, target_value, shift_amount,
                   dest_index, return_address, input ready);
    modport sink(input valid, func, source_value, target_value, shift_amount,
                 dest_index, return_address, output ready);
endinterface

interface mrx_out_if;
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [4:0]  write_index;
    logic [63:0] write_value;
    logic        jump_taken;
    logic [63:0] jump_address;
    logic        overflow_trap;
    modport source(output valid, write_enable, write_index, write_value, jump_taken,
                   jump_address, overflow_trap, input ready);
    modport sink(input valid, write_enable, write_index, write_value, jump_taken,
                 jump_address, overflow_trap, output ready);
endinterface

FILE: rtl/core/mrx_front.sv
module mrx_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mrx_in_if.sink        in_ch,
    output mrx_pkg::t_op  o_op,
    output logic          o_valid,
    input  logic          i_pop
);
    mrx_pkg::t_op r_q [mrx_pkg::QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    mrx_pkg::t_op w_op;
    mrx_pkg::t_kind w_kind;
    logic w_push;

    always_comb begin
        case (in_ch.func)
            mrx_pkg::F_MULT, mrx_pkg::F_MULTU: w_kind = mrx_pkg::K_MUL;
            mrx_pkg::F_DIV, mrx_pkg::F_DIVU:   w_kind = mrx_pkg::K_DIV;
            default:                           w_kind = mrx_pkg::K_ALU;
        endcase
    end

    assign w_op = '{func: in_ch.func, kind: w_kind, rs: in_ch.source_value,
                    rt: in_ch.target_value, sa: in_ch.shift_amount,
                    rd: in_ch.dest_index, ra: in_ch.return_address};
    assign in_ch.ready = (r_cnt != 2'(mrx_pkg::QDEPTH));
    assign w_push = in_ch.valid && in_ch.ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_op = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_op;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(mrx_pkg::QDEPTH)) else $error("queue overfill");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop of empty queue");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_pop) |=> r_cnt == $past(r_cnt) + 2'd1) else $error("count step");
endmodule

FILE: rtl/core/mrx_back.sv
module mrx_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mrx_pkg::t_op  i_op,
    input  logic          i_valid,
    output logic          o_pop,
    mrx_out_if.source     out_ch
);
    mrx_pkg::t_state r_state, n_state;
    mrx_pkg::t_res r_res, w_alu;
    logic [63:0] r_hi, r_lo;
    logic [63:0] r_prod;
    logic [31:0] r_quo, r_rem, r_dvs;
    logic [5:0] r_cnt;
    logic r_qneg, r_rneg;

    logic [63:0] rs, rt, w_val, w_sum, w_dif;
    logic [31:0] w_shr;
    logic w_we, w_ovf;
    logic [32:0] w_trial;

    assign rs = i_op.rs;
    assign rt = i_op.rt;
    assign w_sum = rs + rt;
    assign w_dif = rs - rt;

    always_comb begin
        w_we = 1'b1;
        w_ovf = 1'b0;
        w_val = '0;
        w_shr = '0;
        case (i_op.func)
            mrx_pkg::F_SLL:  w_val = mrx_pkg::sext32(rt[31:0] << i_op.sa);
            mrx_pkg::F_SRL:  w_val = mrx_pkg::sext32(rt[31:0] >> i_op.sa);
            mrx_pkg::F_SRA: begin
                w_shr = 32'($signed(rt) >>> i_op.sa);
                w_val = mrx_pkg::sext32(w_shr);
            end
            mrx_pkg::F_SLLV: w_val = mrx_pkg::sext32(rt[31:0] << rs[4:0]);
            mrx_pkg::F_SRLV: w_val = mrx_pkg::sext32(rt[31:0] >> rs[4:0]);
            mrx_pkg::F_SRAV: begin
                w_shr = 32'($signed(rt) >>> rs[4:0]);
                w_val = mrx_pkg::sext32(w_shr);
            end
            mrx_pkg::F_DSLL:   w_val = rt << i_op.sa;
            mrx_pkg::F_DSLL32: w_val = {rt[31:0] << i_op.sa, 32'd0};
            mrx_pkg::F_DSRA32: w_val = 64'($signed(rt) >>> ({1'b0, i_op.sa} + 6'd32));
            mrx_pkg::F_DSLLV:  w_val = rt << rs[5:0];
            mrx_pkg::F_JALR:   w_val = i_op.ra;
            mrx_pkg::F_MFHI:   w_val = r_hi;
            mrx_pkg::F_MFLO:   w_val = r_lo;
            mrx_pkg::F_ADD: begin
                w_val = mrx_pkg::sext32(w_sum[31:0]);
                w_ovf = ~(rs[31] ^ rt[31]) & (rs[31] ^ w_sum[31]);
            end
            mrx_pkg::F_ADDU: w_val = mrx_pkg::sext32(w_sum[31:0]);
            mrx_pkg::F_SUB: begin
                w_val = mrx_pkg::sext32(w_dif[31:0]);
                w_ovf = (rs[31] ^ rt[31]) & (rs[31] ^ w_dif[31]);
            end
            mrx_pkg::F_SUBU: w_val = mrx_pkg::sext32(w_dif[31:0]);
            mrx_pkg::F_AND:  w_val = rs & rt;
            mrx_pkg::F_OR:   w_val = rs | rt;
            mrx_pkg::F_XOR:  w_val = rs ^ rt;
            mrx_pkg::F_NOR:  w_val = ~(rs | rt);
            mrx_pkg::F_SLT:  w_val = {63'd0, $signed(rs) < $signed(rt)};
            mrx_pkg::F_SLTU: w_val = {63'd0, rs < rt};
            mrx_pkg::F_DADD: begin
                w_val = w_sum;
                w_ovf = ~(rs[63] ^ rt[63]) & (rs[63] ^ w_sum[63]);
            end
            mrx_pkg::F_DADDU: w_val = w_sum;
            mrx_pkg::F_DSUB: begin
                w_val = w_dif;
                w_ovf = (rs[63] ^ rt[63]) & (rs[63] ^ w_dif[63]);
            end
            default: w_we = 1'b0;
        endcase
        if (w_ovf) w_we = 1'b0;
        w_alu.write_enable = w_we;
        w_alu.write_index = w_we ? i_op.rd : 5'd0;
        w_alu.write_value = w_we ? w_val : 64'd0;
        w_alu.jump_taken = (i_op.func == mrx_pkg::F_JR) || (i_op.func == mrx_pkg::F_JALR);
        w_alu.jump_address = w_alu.jump_taken ? rs : 64'd0;
        w_alu.overflow_trap = w_ovf;
    end

    // restoring divide on magnitudes, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[31]} - {1'b0, r_dvs};

    always_comb begin
        n_state = r_state;
        case (r_state)
            mrx_pkg::S_IDLE:
                if (i_valid) begin
                    case (i_op.kind)
                        mrx_pkg::K_MUL: n_state = mrx_pkg::S_MUL;
                        mrx_pkg::K_DIV: n_state = (i_op.rt[31:0] == 32'd0) ?
                                                  mrx_pkg::S_OUT : mrx_pkg::S_DIV;
                        default:        n_state = mrx_pkg::S_OUT;
                    endcase
                end
            mrx_pkg::S_MUL:  n_state = mrx_pkg::S_OUT;
            mrx_pkg::S_DIV:
                if (r_cnt == 6'(mrx_pkg::DIV_STEPS - 1)) n_state = mrx_pkg::S_DONE;
            mrx_pkg::S_DONE: n_state = mrx_pkg::S_OUT;
            mrx_pkg::S_OUT:  if (out_ch.ready) n_state = mrx_pkg::S_IDLE;
            default:         n_state = mrx_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == mrx_pkg::S_IDLE) && i_valid;
        out_ch.valid = (r_state == mrx_pkg::S_OUT);
        out_ch.write_enable = r_res.write_enable;
        out_ch.write_index = r_res.write_index;
        out_ch.write_value = r_res.write_value;
        out_ch.jump_taken = r_res.jump_taken;
        out_ch.jump_address = r_res.jump_address;
        out_ch.overflow_trap = r_res.overflow_trap;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mrx_pkg::S_IDLE:
                if (i_valid) begin
                    r_res <= (i_op.kind == mrx_pkg::K_ALU) ? w_alu : '0;
                    if (i_op.func == mrx_pkg::F_MULT)
                        r_prod <= 64'($signed(rs[31:0]) * $signed(rt[31:0]));
                    else
                        r_prod <= 64'(rs[31:0] * rt[31:0]);
                    r_qneg <= (i_op.func == mrx_pkg::F_DIV) && (rs[31] ^ rt[31]);
                    r_rneg <= (i_op.func == mrx_pkg::F_DIV) && rs[31];
                    r_quo <= ((i_op.func == mrx_pkg::F_DIV) && rs[31]) ? -rs[31:0] : rs[31:0];
                    r_dvs <= ((i_op.func == mrx_pkg::F_DIV) && rt[31]) ? -rt[31:0] : rt[31:0];
                    r_rem <= '0;
                    r_cnt <= '0;
                end
            mrx_pkg::S_DIV: begin
                r_cnt <= r_cnt + 6'd1;
                if (!w_trial[32]) r_rem <= w_trial[31:0];
                else r_rem <= {r_rem[30:0], r_quo[31]};
                r_quo <= {r_quo[30:0], ~w_trial[32]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrx_pkg::S_IDLE;
            r_hi <= '0;
            r_lo <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == mrx_pkg::S_IDLE && i_valid) begin
                if (i_op.func == mrx_pkg::F_MTHI) r_hi <= rs;
                if (i_op.func == mrx_pkg::F_MTLO) r_lo <= rs;
                if (i_op.kind == mrx_pkg::K_DIV && rt[31:0] == 32'd0) begin
                    r_hi <= mrx_pkg::sext32(rs[31:0]);
                    r_lo <= ((i_op.func == mrx_pkg::F_DIV) && rs[31]) ? 64'd1 : '1;
                end
            end
            if (r_state == mrx_pkg::S_MUL) begin
                r_lo <= mrx_pkg::sext32(r_prod[31:0]);
                r_hi <= mrx_pkg::sext32(r_prod[63:32]);
            end
            if (r_state == mrx_pkg::S_DONE) begin
                r_lo <= mrx_pkg::sext32(r_qneg ? -r_quo : r_quo);
                r_hi <= mrx_pkg::sext32(r_rneg ? -r_rem : r_rem);
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == mrx_pkg::S_IDLE) else $error("pop while busy");
    a_ovf_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.overflow_trap) |-> !out_ch.write_enable)
        else $error("write on overflow");
endmodule

FILE: rtl/core/mips64_rtype_execute_unit.sv
// from transfer in to result valid: queued, taken in S_IDLE, then S_OUT for alu ops
// and moves, S_MUL then S_OUT for mult/multu, S_DIV, S_DONE, S_OUT for div/divu
// (S_OUT directly on divide by zero); the back end runs one item at a time, the
// divide iterates one quotient bit per cycle, a 2-entry queue decouples intake
// reset: synchronous active low; clears queue, back-end state, hi and lo
module mips64_rtype_execute_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    mrx_in_if.sink    in_ch,
    mrx_out_if.source out_ch
);
    mrx_pkg::t_op w_op;
    logic w_valid, w_pop;

    mrx_front u_front (.i_clk, .i_rst_n, .in_ch, .o_op(w_op), .o_valid(w_valid),
                       .i_pop(w_pop));
    mrx_back u_back (.i_clk, .i_rst_n, .i_op(w_op), .i_valid(w_valid), .o_pop(w_pop),
                     .out_ch);
endmodule

FILE: verif/mrx_checker.sv
`timescale 1ns / 100ps
module mrx_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrx_in_if.sink    in_mon,
    mrx_out_if.sink   out_mon,
    output int        o_errors
);

    typedef struct {
        logic        write_enable;
        logic [4:0]  write_index;
        logic [63:0] write_value;
        logic        jump_taken;
        logic [63:0] jump_address;
        logic        overflow_trap;
    } t_outcome;

    t_outcome    pending_results[$];
    logic [63:0] hi_q;
    logic [63:0] lo_q;

    initial o_errors = 0;

    function automatic logic [63:0] sx(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    task automatic execute_op(input logic [5:0] fn, input logic [63:0] rs,
                              input logic [63:0] rt, input logic [4:0] sa,
                              input logic [4:0] rd, input logic [63:0] ra);
        t_outcome    o;
        logic [63:0] val;
        logic [63:0] r;
        logic        we;
        logic        jmp;
        logic        ovf;
        logic signed [63:0] a;
        logic signed [63:0] b;
        we = 0; jmp = 0; ovf = 0; val = '0; r = '0;
        case (fn)
            mrx_pkg::F_SLL:    begin we = 1; val = sx({32'b0, rt[31:0]} << sa); end
            mrx_pkg::F_SRL:    begin we = 1; val = sx({32'b0, rt[31:0]} >> sa); end
            mrx_pkg::F_SRA:    begin we = 1; val = sx($signed(rt) >>> sa); end
            mrx_pkg::F_SLLV:   begin we = 1; val = sx({32'b0, rt[31:0]} << rs[4:0]); end
            mrx_pkg::F_SRLV:   begin we = 1; val = sx({32'b0, rt[31:0]} >> rs[4:0]); end
            mrx_pkg::F_SRAV:   begin we = 1; val = sx($signed(rt) >>> rs[4:0]); end
            mrx_pkg::F_DSLL:   begin we = 1; val = rt << sa; end
            mrx_pkg::F_DSLL32: begin we = 1; val = rt << (7'(sa) + 7'd32); end
            mrx_pkg::F_DSRA32: begin we = 1; val = $signed(rt) >>> (7'(sa) + 7'd32); end
            mrx_pkg::F_DSLLV:  begin we = 1; val = rt << rs[5:0]; end
            mrx_pkg::F_JR:     jmp = 1;
            mrx_pkg::F_JALR:   begin jmp = 1; we = 1; val = ra; end
            mrx_pkg::F_SYNC:   ;
            mrx_pkg::F_MFHI:   begin we = 1; val = hi_q; end
            mrx_pkg::F_MTHI:   hi_q = rs;
            mrx_pkg::F_MFLO:   begin we = 1; val = lo_q; end
            mrx_pkg::F_MTLO:   lo_q = rs;
            mrx_pkg::F_MULT: begin
                r = sx(rs) * sx(rt);
                lo_q = sx(r); hi_q = sx(r >> 32);
            end
            mrx_pkg::F_MULTU: begin
                r = {32'b0, rs[31:0]} * {32'b0, rt[31:0]};
                lo_q = sx(r); hi_q = sx(r >> 32);
            end
            mrx_pkg::F_DIV: begin
                if (rt[31:0] == 0) begin
                    lo_q = rs[31] ? 64'd1 : '1;
                    hi_q = sx(rs);
                end else begin
                    a = sx(rs); b = sx(rt);
                    lo_q = sx(a / b); hi_q = sx(a % b);
                end
            end
            mrx_pkg::F_DIVU: begin
                if (rt[31:0] == 0) begin
                    lo_q = '1; hi_q = sx(rs);
                end else begin
                    lo_q = sx({32'b0, rs[31:0]} / {32'b0, rt[31:0]});
                    hi_q = sx({32'b0, rs[31:0]} % {32'b0, rt[31:0]});
                end
            end
            mrx_pkg::F_ADD: begin
                r = rs + rt;
                ovf = ~(rs[31] ^ rt[31]) & (rs[31] ^ r[31]);
                we = 1; val = sx(r);
            end
            mrx_pkg::F_ADDU:  begin we = 1; val = sx(rs + rt); end
            mrx_pkg::F_SUB: begin
                r = rs - rt;
                ovf = (rs[31] ^ rt[31]) & (rs[31] ^ r[31]);
                we = 1; val = sx(r);
            end
            mrx_pkg::F_SUBU:  begin we = 1; val = sx(rs - rt); end
            mrx_pkg::F_AND:   begin we = 1; val = rs & rt; end
            mrx_pkg::F_OR:    begin we = 1; val = rs | rt; end
            mrx_pkg::F_XOR:   begin we = 1; val = rs ^ rt; end
            mrx_pkg::F_NOR:   begin we = 1; val = ~(rs | rt); end
            mrx_pkg::F_SLT: begin
                we = 1; val = ($signed(rs) < $signed(rt)) ? 64'd1 : 64'd0;
            end
            mrx_pkg::F_SLTU:  begin we = 1; val = (rs < rt) ? 64'd1 : 64'd0; end
            mrx_pkg::F_DADD: begin
                r = rs + rt;
                ovf = ~(rs[63] ^ rt[63]) & (rs[63] ^ r[63]);
                we = 1; val = r;
            end
            mrx_pkg::F_DADDU: begin we = 1; val = rs + rt; end
            mrx_pkg::F_DSUB: begin
                r = rs - rt;
                ovf = (rs[63] ^ rt[63]) & (rs[63] ^ r[63]);
                we = 1; val = r;
            end
            default: ;
        endcase
        if (ovf) we = 0;
        o.write_enable  = we;
        o.write_index   = we ? rd : 5'd0;
        o.write_value   = we ? val : 64'd0;
        o.jump_taken    = jmp;
        o.jump_address  = jmp ? rs : 64'd0;
        o.overflow_trap = ovf;
        pending_results.push_back(o);
    endtask

    always @(posedge i_clk) begin
        t_outcome w;
        if (!i_rst_n) begin
            hi_q <= '0;
            lo_q <= '0;
            pending_results.delete();
        end else begin
            if (in_mon.valid && in_mon.ready)
                execute_op(in_mon.func, in_mon.source_value, in_mon.target_value,
                           in_mon.shift_amount, in_mon.dest_index,
                           in_mon.return_address);
            if (out_mon.valid && out_mon.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", out_mon.write_value, '0);
                end else begin
                    w = pending_results.pop_front();
                    if (out_mon.write_enable !== w.write_enable)
                        report_mismatch("write_enable", 64'(out_mon.write_enable),
                                        64'(w.write_enable));
                    if (out_mon.write_index !== w.write_index)
                        report_mismatch("write_index", 64'(out_mon.write_index),
                                        64'(w.write_index));
                    if (out_mon.write_value !== w.write_value)
                        report_mismatch("write_value", out_mon.write_value,
                                        w.write_value);
                    if (out_mon.jump_taken !== w.jump_taken)
                        report_mismatch("jump_taken", 64'(out_mon.jump_taken),
                                        64'(w.jump_taken));
                    if (out_mon.jump_address !== w.jump_address)
                        report_mismatch("jump_address", out_mon.jump_address,
                                        w.jump_address);
                    if (out_mon.overflow_trap !== w.overflow_trap)
                        report_mismatch("overflow_trap", 64'(out_mon.overflow_trap),
                                        64'(w.overflow_trap));
                end
            end
        end
    end

    function automatic int outstanding();
        return pending_results.size();
    endfunction

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
module tb;

    localparam int IDLE_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    int   checker_errors;
    int   idle_cycles;
    bit   steady;

    mrx_in_if  in_ch();
    mrx_out_if out_ch();

    mips64_rtype_execute_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    mrx_checker i_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .in_mon   (in_ch.sink),
        .out_mon  (out_ch.sink),
        .o_errors (checker_errors)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 0;
        else
            out_ch.ready <= steady || ($urandom_range(99) >= 17);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(9))
            0: return 64'h0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7fff_ffff_ffff_ffff;
            4: return {32'h0, 32'h8000_0000};
            5: return {{32{1'b1}}, 32'h8000_0000};
            6: return {32'h0, 32'h7fff_ffff};
            7: return 64'($urandom_range(40));
            default: return rand64();
        endcase
    endfunction

    task automatic send_op(input logic [5:0] fn, input logic [63:0] rs,
                           input logic [63:0] rt, input logic [4:0] sa);
        if (!steady) begin
            while ($urandom_range(99) < 17) begin
                in_ch.valid <= 0;
                @(posedge i_clk);
            end
        end
        in_ch.valid          <= 1;
        in_ch.func           <= fn;
        in_ch.source_value   <= rs;
        in_ch.target_value   <= rt;
        in_ch.shift_amount   <= sa;
        in_ch.dest_index     <= 5'($urandom);
        in_ch.return_address <= rand64();
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    initial begin
        logic [5:0] fn;
        i_rst_n = 0;
        steady = 0;
        idle_cycles = 0;
        in_ch.valid = 0;
        in_ch.func = '0;
        in_ch.source_value = '0;
        in_ch.target_value = '0;
        in_ch.shift_amount = '0;
        in_ch.dest_index = '0;
        in_ch.return_address = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed corners
        send_op(mrx_pkg::F_MFHI, '0, '0, 5'd0);
        send_op(mrx_pkg::F_MFLO, '0, '0, 5'd0);
        send_op(mrx_pkg::F_SLL, '0, '1, 5'd31);
        send_op(mrx_pkg::F_SRA, '0, 64'h8000_0000_0000_0000, 5'd31);
        send_op(mrx_pkg::F_DSRA32, '0, 64'h8000_0000_0000_0000, 5'd31);
        send_op(mrx_pkg::F_DSLLV, 64'd63, '1, 5'd0);
        send_op(mrx_pkg::F_ADD, 64'h7fff_ffff, 64'd1, 5'd0);
        send_op(mrx_pkg::F_SUB, 64'h8000_0000, 64'd1, 5'd0);
        send_op(mrx_pkg::F_DADD, 64'h7fff_ffff_ffff_ffff, 64'd1, 5'd0);
        send_op(mrx_pkg::F_DSUB, 64'h8000_0000_0000_0000, 64'd1, 5'd0);
        send_op(mrx_pkg::F_DIV, 64'h8000_0000, '1, 5'd0);
        send_op(mrx_pkg::F_MFLO, '0, '0, 5'd0);
        send_op(mrx_pkg::F_DIV, 64'h8000_0000, 64'h1_0000_0000, 5'd0);
        send_op(mrx_pkg::F_MFLO, '0, '0, 5'd0);
        send_op(mrx_pkg::F_DIV, 64'd5, '0, 5'd0);
        send_op(mrx_pkg::F_MFHI, '0, '0, 5'd0);
        send_op(mrx_pkg::F_DIVU, '1, '0, 5'd0);
        send_op(mrx_pkg::F_MULT, '1, 64'h8000_0000, 5'd0);
        send_op(mrx_pkg::F_MFHI, '0, '0, 5'd0);
        send_op(mrx_pkg::F_MULTU, '1, '1, 5'd0);
        send_op(mrx_pkg::F_MFLO, '0, '0, 5'd0);
        send_op(mrx_pkg::F_JALR, '1, '0, 5'd0);
        send_op(mrx_pkg::F_JR, 64'h1234, '0, 5'd0);
        send_op(mrx_pkg::F_SYNC, '1, '1, 5'd31);
        send_op(6'd63, '1, '1, 5'd31);

        for (int n = 0; n < 1950; n++) begin
            steady = (n >= 800 && n < 1100);
            case ($urandom_range(19))
                0:       fn = 6'($urandom_range(34, 63));
                1, 2:    fn = $urandom_range(1) ? mrx_pkg::F_MFHI : mrx_pkg::F_MFLO;
                default: fn = 6'($urandom_range(33));
            endcase
            send_op(fn, pick_operand(), pick_operand(), 5'($urandom));
        end
        in_ch.valid <= 0;

        while (i_checker.outstanding() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (checker_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
